// File: sv/multichannel_peak_to_peak_averager_defines.svh
// Assertion macros for the peak-to-peak averager.
`ifndef MULTICHANNEL_PEAK_TO_PEAK_AVERAGER_DEFINES_SVH
`define MULTICHANNEL_PEAK_TO_PEAK_AVERAGER_DEFINES_SVH

// Condition holds in the same cycle.
`define MPA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition holds in the next cycle.
`define MPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/mpa_pkg.sv
// Shared constants, types and helpers of the peak-to-peak averager.
`timescale 1ns / 1ps
package mpa_pkg;
  localparam int CONVERTERS  = 4;
  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;
  localparam int COUNT_BITS  = 16;
  localparam int SLOTS       = CONVERTERS * CHANNELS;
  localparam int SLOT_BITS   = $clog2(SLOTS);
  localparam int CONV_BITS   = 2;
  localparam int CHAN_BITS   = 2;
  localparam int SUM_BITS    = 28;
  localparam int VREF_BITS   = 12;
  localparam int PROD_BITS   = 24;
  localparam int QDEPTH      = 2;

  localparam logic [CONV_BITS-1:0]   LAST_CONV  = CONV_BITS'(CONVERTERS - 1);
  localparam logic [SAMPLE_BITS-1:0] RAW_MAX    = 12'd4095;
  localparam logic [SUM_BITS-1:0]    SUM_MAX    = '1;
  localparam logic [VREF_BITS-1:0]   VREF_RESET = 12'd2900;
  localparam logic [COUNT_BITS-1:0]  WIN_RESET  = 16'd1;
  localparam logic [PROD_BITS-1:0]   HALF_FULL  = 24'd2047;

  typedef logic [SLOTS-1:0][SAMPLE_BITS-1:0] snap_t;

  // x / 4095 for x below 2**24: estimate, then one correction.
  function automatic logic [SAMPLE_BITS-1:0] div_full(input logic [PROD_BITS-1:0] x);
    logic [PROD_BITS:0]   est;
    logic [PROD_BITS:0]   q;
    logic [PROD_BITS+1:0] r;
    est = ({1'b0, x} + {13'd0, x[PROD_BITS-1:12]}) >> 12;
    q   = est;
    // remainder x - 4095 * q
    r   = (PROD_BITS+2)'(x) - ((PROD_BITS+2)'(q) << 12) + (PROD_BITS+2)'(q);
    if (r >= (PROD_BITS+2)'(4095)) q = q + 1'b1;
    return q[SAMPLE_BITS-1:0];
  endfunction
endpackage

// File: sv/mpa_front.sv
// Front end: running extremes per channel and window latches.
`timescale 1ns / 1ps
module mpa_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [mpa_pkg::CONV_BITS-1:0]    conv_i,
  input  logic [mpa_pkg::CHANNELS-1:0][mpa_pkg::SAMPLE_BITS-1:0] smp_i,
  input  logic                             last_i,
  output logic                             rpt_push_o,
  output mpa_pkg::snap_t                   rpt_snap_o
);
  import mpa_pkg::*;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] min_q, max_q, min_d, max_d, nmin, nmax;
  snap_t p2p_q, p2p_d;

  always_comb begin
    p2p_d = p2p_q;
    min_d = min_q;
    max_d = max_q;
    for (int c = 0; c < CHANNELS; c++) begin
      nmin[c] = (smp_i[c] < min_q[c]) ? smp_i[c] : min_q[c];
      nmax[c] = (smp_i[c] > max_q[c]) ? smp_i[c] : max_q[c];
    end
    if (accept_i) begin
      min_d = nmin;
      max_d = nmax;
      if (last_i) begin
        for (int c = 0; c < CHANNELS; c++) begin
          p2p_d[SLOT_BITS'(conv_i) * SLOT_BITS'(CHANNELS) + SLOT_BITS'(c)] =
            (nmax[c] >= nmin[c]) ? nmax[c] - nmin[c] : '0;
          min_d[c] = '1;
          max_d[c] = '0;
        end
      end
    end
  end

  assign rpt_push_o = accept_i && last_i && (conv_i == LAST_CONV);
  assign rpt_snap_o = p2p_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= '1;
      max_q <= '0;
    end else begin
      min_q <= min_d;
      max_q <= max_d;
    end
  end

  // latches have no reset: read only after written
  always_ff @(posedge clk_i) begin
    p2p_q <= p2p_d;
  end
endmodule

// File: sv/mpa_queue.sv
// Short report queue between front and back.
`timescale 1ns / 1ps
module mpa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mpa_pkg::snap_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output mpa_pkg::snap_t data_o
);
  import mpa_pkg::*;

  localparam int PB = $clog2(QDEPTH);

  snap_t           mem_q [QDEPTH];
  logic [PB-1:0]   wp_q, rp_q;
  logic [PB:0]     cnt_q;

  assign full_o  = (cnt_q == (PB+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (PB+1)'(push_i) - (PB+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end
endmodule

// File: sv/mpa_back.sv
// Back end: block sums, averaging divider, scaling and result register.
`timescale 1ns / 1ps
`include "multichannel_peak_to_peak_averager_defines.svh"
module mpa_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               rpt_valid_i,
  input  mpa_pkg::snap_t                     rpt_snap_i,
  output logic                               rpt_pop_o,
  input  logic [mpa_pkg::COUNT_BITS-1:0]     window_i,
  input  logic [mpa_pkg::VREF_BITS-1:0]      vref_i,
  input  logic                               pop_i,
  output logic                               empty_o,
  output logic [mpa_pkg::CONV_BITS-1:0]      conv_o,
  output logic [mpa_pkg::CHAN_BITS-1:0]      chan_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]    p2p_raw_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]    avg_raw_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]    inst_mv_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]    avg_mv_o,
  output logic [mpa_pkg::COUNT_BITS-1:0]     count_o,
  output logic                               last_o
);
  import mpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SUM  = 5'b00010,
    S_DIV  = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  localparam int DC_BITS = $clog2(SUM_BITS + 1);

  state_e                    state_q, state_d;
  logic [SUM_BITS-1:0]       sums_q [SLOTS];
  logic [COUNT_BITS-1:0]     count_q;
  logic                      clr_q;
  logic [SLOT_BITS-1:0]      slot_q;
  logic [SUM_BITS-1:0]       quo_q;
  logic [COUNT_BITS:0]       rem_q;
  logic [DC_BITS-1:0]        dcnt_q;
  logic [PROD_BITS-1:0]      pinst_q, pavg_q;
  logic                      out_valid_q;
  logic [SAMPLE_BITS-1:0]    inst, avg;
  logic [SUM_BITS:0]         sum_w;
  logic [SUM_BITS-1:0]       sum_sat;
  logic [COUNT_BITS:0]       rem_sh;
  logic                      load_out, last_slot;

  assign inst      = rpt_snap_i[slot_q];
  assign avg       = (quo_q > SUM_BITS'(RAW_MAX)) ? RAW_MAX : quo_q[SAMPLE_BITS-1:0];
  assign sum_w     = {1'b0, clr_q ? SUM_BITS'(0) : sums_q[slot_q]} + (SUM_BITS+1)'(inst);
  assign sum_sat   = sum_w[SUM_BITS] ? SUM_MAX : sum_w[SUM_BITS-1:0];
  assign rem_sh    = {rem_q[COUNT_BITS-1:0], quo_q[SUM_BITS-1]};
  assign load_out  = (state_q == S_EMIT) && (!out_valid_q || pop_i);
  assign last_slot = (slot_q == SLOT_BITS'(SLOTS - 1));
  assign rpt_pop_o = load_out && last_slot;
  assign empty_o   = !out_valid_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (rpt_valid_i) state_d = S_SUM;
      S_SUM:   state_d = S_DIV;
      S_DIV:   if (dcnt_q == '0) state_d = S_MUL;
      S_MUL:   state_d = S_EMIT;
      S_EMIT:  if (load_out) state_d = last_slot ? S_IDLE : S_SUM;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      clr_q       <= 1'b0;
      slot_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SLOTS; i++) sums_q[i] <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out || (out_valid_q && !pop_i);
      unique case (state_q)
        S_IDLE: begin
          if (rpt_valid_i) begin
            clr_q  <= (count_q == '0);
            slot_q <= '0;
            if (count_q < window_i && count_q != '1) count_q <= count_q + 1'b1;
          end
        end
        S_SUM: begin
          sums_q[slot_q] <= sum_sat;
          dcnt_q         <= DC_BITS'(SUM_BITS - 1);
        end
        S_DIV: begin
          if (dcnt_q != '0) dcnt_q <= dcnt_q - 1'b1;
        end
        S_MUL: ;
        S_EMIT: begin
          if (load_out) begin
            slot_q      <= slot_q + 1'b1;
            // close the block once the window is reached
            if (last_slot && count_q >= window_i) count_q <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // restoring divide, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_SUM) begin
      quo_q <= sum_sat;
      rem_q <= '0;
    end else if (state_q == S_DIV) begin
      if (rem_sh >= {1'b0, count_q}) begin
        rem_q <= rem_sh - {1'b0, count_q};
        quo_q <= {quo_q[SUM_BITS-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[SUM_BITS-2:0], 1'b0};
      end
    end
    if (state_q == S_MUL) begin
      pinst_q <= PROD_BITS'(inst) * PROD_BITS'(vref_i) + HALF_FULL;
      pavg_q  <= PROD_BITS'(avg) * PROD_BITS'(vref_i) + HALF_FULL;
    end
    if (load_out) begin
      conv_o     <= slot_q[SLOT_BITS-1 -: CONV_BITS];
      chan_o     <= slot_q[CHAN_BITS-1:0];
      p2p_raw_o  <= inst;
      avg_raw_o  <= avg;
      inst_mv_o  <= div_full(pinst_q);
      avg_mv_o   <= div_full(pavg_q);
      count_o    <= count_q;
      last_o     <= last_slot;
    end
  end

  `MPA_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state_q))
  `MPA_ASSERT_NEXT(a_out_hold, out_valid_q && !pop_i, out_valid_q)
  `MPA_ASSERT_NEXT(a_report_done, rpt_pop_o, state_q == S_IDLE && out_valid_q)
  `MPA_ASSERT_NOW(a_count_active, state_q != S_IDLE, count_q != '0)
endmodule

// File: sv/multichannel_peak_to_peak_averager.sv
// Top level: queue handshakes, configuration registers, front and back.
//  conv  channels  sample ports             p2p slots
//  0     0..3      sample_ch0_i..ch3_i      0..3
//  1     0..3      sample_ch0_i..ch3_i      4..7
//  2     0..3      sample_ch0_i..ch3_i      8..11
//  3     0..3      sample_ch0_i..ch3_i      12..15 (closes the report)
// A frame is taken every cycle while full is low; full rises only when both
// report slots of the front-to-back queue are taken.
// Each report is worked through slot by slot in the back end (sum, bit-serial divide,
// scale, load), one report at a time, then returns to idle; the divider makes one bit a cycle;
// results leave through one output register, and a result not popped holds the back end.
// Reset is asynchronous and active low; no clearing pass is needed.
`timescale 1ns / 1ps
module multichannel_peak_to_peak_averager (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [mpa_pkg::CONV_BITS-1:0]     converter_index_i,
  input  logic [mpa_pkg::SAMPLE_BITS-1:0]   sample_ch0_i,
  input  logic [mpa_pkg::SAMPLE_BITS-1:0]   sample_ch1_i,
  input  logic [mpa_pkg::SAMPLE_BITS-1:0]   sample_ch2_i,
  input  logic [mpa_pkg::SAMPLE_BITS-1:0]   sample_ch3_i,
  input  logic                              last_frame_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [mpa_pkg::CONV_BITS-1:0]     converter_number_o,
  output logic [mpa_pkg::CHAN_BITS-1:0]     channel_number_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]   instant_raw_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]   average_raw_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]   instant_millivolts_o,
  output logic [mpa_pkg::SAMPLE_BITS-1:0]   average_millivolts_o,
  output logic [mpa_pkg::COUNT_BITS-1:0]    reports_in_block_o,
  output logic                              last_result_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import mpa_pkg::*;

  typedef enum logic {
    REG_WINDOW = 1'b0,
    REG_VREF   = 1'b1
  } reg_e;

  logic [COUNT_BITS-1:0] window_q;
  logic [VREF_BITS-1:0]  vref_q;
  logic                  accept;
  logic                  rpt_push, rpt_full;
  snap_t                 push_snap, head_snap;
  logic                  head_valid, head_pop;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] smp;

  assign pready = 1'b1;
  assign prdata = (reg_e'(paddr[2]) == REG_WINDOW) ? 32'(window_q) : 32'(vref_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WIN_RESET;
      vref_q   <= VREF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_e'(paddr[2]))
        REG_WINDOW: window_q <= (pwdata[15:0] == '0) ? WIN_RESET : pwdata[15:0];
        REG_VREF:   vref_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  assign full   = rpt_full;
  assign accept = push && !rpt_full;
  assign smp    = {sample_ch3_i, sample_ch2_i, sample_ch1_i, sample_ch0_i};

  mpa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .conv_i     (converter_index_i),
    .smp_i      (smp),
    .last_i     (last_frame_i),
    .rpt_push_o (rpt_push),
    .rpt_snap_o (push_snap)
  );

  mpa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rpt_push),
    .data_i  (push_snap),
    .full_o  (rpt_full),
    .pop_i   (head_pop),
    .valid_o (head_valid),
    .data_o  (head_snap)
  );

  mpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rpt_valid_i (head_valid),
    .rpt_snap_i  (head_snap),
    .rpt_pop_o   (head_pop),
    .window_i    (window_q),
    .vref_i      (vref_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .conv_o      (converter_number_o),
    .chan_o      (channel_number_o),
    .p2p_raw_o   (instant_raw_o),
    .avg_raw_o   (average_raw_o),
    .inst_mv_o   (instant_millivolts_o),
    .avg_mv_o    (average_millivolts_o),
    .count_o     (reports_in_block_o),
    .last_o      (last_result_o)
  );
endmodule
